>>> design/accumulator_machine_executor_top_macros.svh
// Assertion macros used by the executor top level.
`ifndef ACCUMULATOR_MACHINE_EXECUTOR_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AMX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/amx_pkg.sv
// Shared types, constants and helpers of the accumulator machine executor.
package amx_pkg;

  localparam int MEM_WORDS  = 512;
  localparam int WORD_BITS  = 32;
  localparam int MEM_AW     = $clog2(MEM_WORDS);
  localparam int ADDR_BITS  = 10;
  localparam int ACT_BITS   = 4;
  localparam int SRC_BITS   = 2;
  localparam int IMM_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_BITS  = $clog2(MEM_WORDS + (1 << ADDR_BITS)) + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [MEM_AW-1:0]    mem_addr_t;
  typedef logic [ADDR_BITS-1:0] op_addr_t;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_SET   = 4'd0,
    ACT_ADD   = 4'd1,
    ACT_SUB   = 4'd2,
    ACT_INC   = 4'd3,
    ACT_DEC   = 4'd4,
    ACT_MOV   = 4'd5,
    ACT_LDR   = 4'd6,
    ACT_STR   = 4'd7,
    ACT_SHW   = 4'd8,
    ACT_PAUSE = 4'd9
  } action_t;

  typedef enum logic [SRC_BITS-1:0] {
    SRC_MEM = 2'd0,
    SRC_ACC = 2'd1,
    SRC_MAR = 2'd2,
    SRC_MDR = 2'd3
  } show_src_t;

  typedef struct packed {
    logic      en;
    mem_addr_t addr;
    word_t     data;
  } mem_wr_t;

  typedef struct packed {
    logic      en;
    mem_addr_t addr_a;
    mem_addr_t addr_b;
  } mem_rd_t;

  // One-based operand address to word index; zero wraps to the last word.
  function automatic mem_addr_t slot_of(input op_addr_t a);
    logic [SLOT_BITS-1:0] sum;
    sum = SLOT_BITS'(a) + SLOT_BITS'(MEM_WORDS - 1);
    return MEM_AW'(sum % MEM_WORDS);
  endfunction

endpackage

>>> design/amx_mem.sv
// Data memory: one write port, two registered read ports.
module amx_mem
  import amx_pkg::*;
(
  input  logic    clk,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output word_t   rd_data_a,
  output word_t   rd_data_b
);

  word_t mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Hold read data between reads.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_a <= mem[rd.addr_a];
      rd_data_b <= mem[rd.addr_b];
    end
  end

endmodule

>>> design/accumulator_machine_executor_top.sv
// Accumulator machine executor: top level with sequencer, registers and output stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded instruction per item;
//   output channel (out_valid/out_ready) returns exactly one result item per
//   instruction: show_valid, show_value and paused_now.
//   An accepted item is latched together with its operand reads and executes in
//   ST_EXEC once the output register is free; its result is then registered there.
//   The pace is set by the data memory: operands are read through its registered
//   read ports at acceptance, and its single write port takes MOV's two writes
//   (destination, then source).
//   Reset: the sequencer sweeps the 512-word data memory to zero, one word per
//   cycle, and in_ready stays low until the sweep is done. The accumulator, MAR,
//   MDR and pause flag clear at once.
//   Stall: a result waits in the output register; an instruction in execution
//   holds (no memory write, no register update) until that register frees up.
//   A new item is taken only when the previous one has fully written back, so
//   no forwarding is needed between consecutive items.
`include "accumulator_machine_executor_top_macros.svh"

module accumulator_machine_executor_top
  import amx_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ACT_BITS-1:0]          action,
  input  logic [ADDR_BITS-1:0]         addr_first,
  input  logic [ADDR_BITS-1:0]         addr_second,
  input  logic [ADDR_BITS-1:0]         addr_third,
  input  logic                         has_second,
  input  logic                         has_third,
  input  logic signed [IMM_BITS-1:0]   immediate,
  input  logic [SRC_BITS-1:0]          show_source,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         show_valid,
  output logic signed [VALUE_BITS-1:0] show_value,
  output logic                         paused_now
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_ZERO  = 4'b1000
  } state_t;

  localparam mem_addr_t CLR_LAST = MEM_AW'(MEM_WORDS - 1);

  state_t state, state_next;
  mem_addr_t clr_addr;

  // Latched instruction.
  logic [ACT_BITS-1:0]        op;
  op_addr_t                   addr1, addr2, addr3;
  logic                       has2, has3;
  logic signed [IMM_BITS-1:0] imm;
  logic [SRC_BITS-1:0]        src;

  // Architectural state.
  word_t    acc, acc_next;
  op_addr_t mar, mar_next;
  word_t    mdr, mdr_next;
  logic     paused, paused_next;

  logic                  accept, out_load;
  logic                  shw_valid_next;
  logic [VALUE_BITS-1:0] shw_value_next;

  mem_wr_t wr;
  mem_rd_t rd;
  word_t   rd_a, rd_b;
  word_t   lhs, rhs, opnd_a, opnd_b, alu_res;
  logic    is_step, is_sub;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_EXEC) && (!out_valid || out_ready);

  // Issue both operand reads straight from the input item.
  assign rd.en     = accept;
  assign rd.addr_a = slot_of(addr_first);
  assign rd.addr_b = slot_of(addr_second);

  amx_mem u_mem (
    .clk       (clk),
    .wr        (wr),
    .rd        (rd),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Shared add/subtract unit: one-operand form uses the accumulator on the left.
  assign is_step = (op == ACT_INC) || (op == ACT_DEC);
  assign is_sub  = (op == ACT_SUB) || (op == ACT_DEC);
  assign lhs     = has2 ? rd_a : acc;
  assign rhs     = has2 ? rd_b : rd_a;
  assign opnd_a  = is_step ? rd_a : lhs;
  assign opnd_b  = is_step ? word_t'(1) : rhs;
  assign alu_res = is_sub ? (opnd_a - opnd_b) : (opnd_a + opnd_b);

  always_comb begin
    acc_next       = acc;
    mar_next       = mar;
    mdr_next       = mdr;
    paused_next    = paused;
    shw_valid_next = 1'b0;
    shw_value_next = '0;
    wr             = '0;
    case (state)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_addr;
      end
      ST_ZERO: begin
        // Second write of MOV: clear the source after the copy.
        wr.en   = 1'b1;
        wr.addr = slot_of(addr1);
      end
      ST_EXEC: begin
        if (out_load) begin
          if (op == ACT_PAUSE) begin
            paused_next = !paused;
          end else if (op == ACT_SHW) begin
            if (src == SRC_MEM) begin
              shw_valid_next = 1'b1;
              shw_value_next = VALUE_BITS'(rd_a);
            end else if (paused) begin
              shw_valid_next = 1'b1;
              case (src)
                SRC_ACC: shw_value_next = VALUE_BITS'(acc);
                SRC_MAR: shw_value_next = VALUE_BITS'(mar);
                default: shw_value_next = VALUE_BITS'(mdr);
              endcase
            end
          end else if (!paused) begin
            case (op)
              ACT_SET: begin
                wr.en   = 1'b1;
                wr.addr = slot_of(addr1);
                wr.data = word_t'(imm);
              end
              ACT_ADD, ACT_SUB: begin
                acc_next = alu_res;
                if (!has2) begin
                  mar_next = addr1;
                  mdr_next = rd_a;
                end else if (!has3) begin
                  mar_next = addr2;
                  mdr_next = rd_b;
                end else begin
                  wr.en    = 1'b1;
                  wr.addr  = slot_of(addr3);
                  wr.data  = alu_res;
                  mar_next = addr3;
                  mdr_next = alu_res;
                end
              end
              ACT_INC, ACT_DEC: begin
                acc_next = alu_res;
                wr.en    = 1'b1;
                wr.addr  = slot_of(addr1);
                wr.data  = alu_res;
                mar_next = addr1;
                mdr_next = alu_res;
              end
              ACT_MOV: begin
                wr.en   = 1'b1;
                wr.addr = slot_of(addr2);
                wr.data = rd_a;
              end
              ACT_LDR: begin
                acc_next = rd_a;
                mar_next = addr1;
                mdr_next = rd_a;
              end
              ACT_STR: begin
                wr.en    = 1'b1;
                wr.addr  = slot_of(addr1);
                wr.data  = acc;
                mar_next = addr1;
                mdr_next = acc;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC: begin
        if (out_load) begin
          state_next = (op == ACT_MOV && !paused) ? ST_ZERO : ST_IDLE;
        end
      end
      ST_ZERO:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      acc       <= '0;
      mar       <= '0;
      mdr       <= '0;
      paused    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      acc    <= acc_next;
      mar    <= mar_next;
      mdr    <= mdr_next;
      paused <= paused_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the instruction on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= action;
      addr1 <= addr_first;
      addr2 <= addr_second;
      addr3 <= addr_third;
      has2  <= has_second;
      has3  <= has_third;
      imm   <= immediate;
      src   <= show_source;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      show_valid <= shw_valid_next;
      show_value <= shw_value_next;
      paused_now <= paused_next;
    end
  end

  `AMX_ASSERT_NEXT(a_accept_to_exec, clk, rst, accept, state == ST_EXEC, "accept did not start execution")
  `AMX_ASSERT_NEXT(a_clear_done, clk, rst, state == ST_CLEAR && clr_addr == CLR_LAST, state == ST_IDLE, "clear pass did not end")
  `AMX_ASSERT_NEXT(a_pause_toggle, clk, rst, out_load && op == ACT_PAUSE, paused != $past(paused) && paused_now == paused, "pause flag not toggled")
  `AMX_ASSERT_NEXT(a_mov_zero, clk, rst, out_load && op == ACT_MOV && !paused, state == ST_ZERO && !out_valid == 1'b0, "mov skipped source clear")
  `AMX_ASSERT_NOW(a_no_write_idle, clk, rst, state == ST_IDLE, !wr.en, "memory written while idle")

endmodule
